// ===== rtl/core/sclp_pkg.sv =====
// Shared types, constants and keyword tables of the serial command line parser.
package sclp_pkg;

  localparam int LINE_CAPACITY = 64;
  localparam int ADDR_W        = $clog2(LINE_CAPACITY);
  localparam int ROW_COUNT     = 8;
  localparam int MAX_RESULTS   = 56;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_LC  = 8'h78;
  localparam logic [7:0] CH_X_UC  = 8'h58;

  localparam logic [2:0] KIND_CLOCK = 3'd0;
  localparam logic [2:0] KIND_PING  = 3'd1;
  localparam logic [2:0] KIND_STYLE = 3'd2;
  localparam logic [2:0] KIND_ALERT = 3'd3;
  localparam logic [2:0] KIND_ROW   = 3'd4;

  localparam logic [1:0] STYLE_ARCS   = 2'd0;
  localparam logic [1:0] STYLE_DOTS   = 2'd1;
  localparam logic [1:0] STYLE_DOTTED = 2'd2;

  // Keywords: the five commands first, then the three style names.
  typedef enum logic [2:0] {
    KW_CLOCK, KW_PING, KW_CSTYLE, KW_ALERT, KW_ROW, KW_ARCS, KW_DOTS, KW_DOTTED
  } kw_t;

  // One classified byte as it travels from the front to the back.
  typedef struct packed {
    logic [7:0] data;
    logic       eol;
  } beat_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  command_kind;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [1:0]  style_code;
    logic        alert_on;
    logic [2:0]  row_number;
    logic [31:0] row_color;
    logic [7:0]  text_char;
    logic        text_present;
    logic        last_of_line;
  } result_t;

  function automatic logic [87:0] kw_text(input kw_t kw);
    logic [87:0] s;
    unique case (kw)
      KW_CLOCK:  s = 88'("CLOCK");
      KW_PING:   s = 88'("PING");
      KW_CSTYLE: s = 88'("CSTYLE");
      KW_ALERT:  s = 88'("ALERT");
      KW_ROW:    s = 88'("ROW");
      KW_ARCS:   s = 88'("arcs");
      KW_DOTS:   s = 88'("dots");
      default:   s = 88'("dotted-arcs");
    endcase
    return s;
  endfunction

  function automatic logic [3:0] kw_len(input kw_t kw);
    logic [3:0] n;
    unique case (kw)
      KW_CLOCK:  n = 4'd5;
      KW_PING:   n = 4'd4;
      KW_CSTYLE: n = 4'd6;
      KW_ALERT:  n = 4'd5;
      KW_ROW:    n = 4'd3;
      KW_ARCS:   n = 4'd4;
      KW_DOTS:   n = 4'd4;
      default:   n = 4'd11;
    endcase
    return n;
  endfunction

  // Character idx of a keyword, or zero past its end.
  function automatic logic [7:0] kw_char(input kw_t kw, input logic [3:0] idx);
    logic [87:0] s;
    logic [3:0]  n;
    logic [3:0]  pos;
    s   = kw_text(kw);
    n   = kw_len(kw);
    pos = n - 4'd1 - idx;
    return (idx < n) ? s[{pos, 3'b000} +: 8] : 8'd0;
  endfunction

endpackage

// ===== rtl/core/sclp_front.sv =====
// Front part: accepts received bytes and marks line ends.
module sclp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,
  output logic                 f_valid,
  input  logic                 f_ready,
  output sclp_pkg::beat_t      f_beat
);

  assign s_tready = !f_valid || f_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      if (f_ready) begin
        f_valid <= 1'b0;
      end
      if (s_tvalid && s_tready) begin
        f_valid     <= 1'b1;
        f_beat.data <= s_tdata;
        f_beat.eol  <= (s_tdata == sclp_pkg::CH_CR) || (s_tdata == sclp_pkg::CH_LF);
      end
    end
  end

endmodule

// ===== rtl/core/sclp_queue.sv =====
// Short queue of classified bytes between the front and the back.
module sclp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sclp_pkg::beat_t  in_beat,
  output logic             out_valid,
  input  logic             out_ready,
  output sclp_pkg::beat_t  out_beat
);

  sclp_pkg::beat_t                  slots [sclp_pkg::QUEUE_DEPTH];
  logic [sclp_pkg::QPTR_W-1:0]      wr_ptr;
  logic [sclp_pkg::QPTR_W-1:0]      rd_ptr;
  logic [sclp_pkg::QPTR_W:0]        count;
  logic                             push;
  logic                             pop;

  assign in_ready  = (count != (sclp_pkg::QPTR_W+1)'(sclp_pkg::QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_beat  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/sclp_back.sv =====
// Back part: line store, character-serial command parser and result register.
module sclp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  sclp_pkg::beat_t      q_beat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sclp_pkg::result_t    out_res
);

  typedef enum logic [3:0] {
    ST_COLLECT, ST_CMD_WS, ST_CMD_WORD, ST_DEC_WS, ST_DEC_SIGN, ST_DEC_DIG,
    ST_STY_WS, ST_STY_WORD, ST_COL_WS, ST_COL_WORD, ST_TXT_WS, ST_TXT, ST_EMIT
  } state_t;

  localparam int AW = sclp_pkg::ADDR_W;

  state_t            state;
  logic [7:0]        mem [sclp_pkg::LINE_CAPACITY];
  logic [7:0]        rd_q;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     len;
  logic              zero_seen;
  logic [AW-1:0]     zero_pos;
  logic [AW-1:0]     eff_len;
  logic [AW-1:0]     p;
  logic [7:0]        match;
  logic [3:0]        cnt;
  sclp_pkg::kw_t     cmd;
  logic [1:0]        dec_idx;
  logic              neg;
  logic [6:0]        mag;
  logic [2:0]        ccnt;
  logic              any;
  logic              zero_only;
  logic              xwait;
  logic              dig_on;
  logic [31:0]       color;
  logic [5:0]        n;
  logic [4:0]        hours;
  logic [5:0]        minutes;
  logic [5:0]        seconds;
  logic [1:0]        style;
  logic              alert;
  logic [2:0]        row;

  logic [7:0]        c;
  logic              at_end;
  logic              ws;
  logic              sign;
  logic              dig;
  logic              hexd;
  logic [3:0]        hv;
  logic              take;
  logic              out_free;
  logic [10:0]       dec_sum;
  logic [6:0]        mag_next;
  logic [6:0]        dec_lim;
  logic              dec_ok;
  logic              txt_last;
  logic              in_word;
  logic              collect_wr;
  logic              emit;
  logic              word_hit;
  logic [2:0]        emit_kind;

  always_comb begin
    at_end = !(p < eff_len);
    c      = at_end ? 8'd0 : rd_q;
    ws     = (c == sclp_pkg::CH_SPACE) || (c == sclp_pkg::CH_TAB) || (c == sclp_pkg::CH_LF)
          || (c == sclp_pkg::CH_VT) || (c == sclp_pkg::CH_FF) || (c == sclp_pkg::CH_CR);
    sign   = (c == sclp_pkg::CH_PLUS) || (c == sclp_pkg::CH_MINUS);
    dig    = (c >= 8'h30) && (c <= 8'h39);
    hexd   = 1'b1;
    hv     = c[3:0];
    if (dig) begin
      hv = c[3:0];
    end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
      hv = c[3:0] + 4'd9;
    end else begin
      hexd = 1'b0;
    end
    out_free = !out_valid || out_ready;
    emit     = out_free && ((state == ST_EMIT) || (state == ST_TXT));
    in_word  = !ws && !at_end && (ccnt != 3'd7);
    dec_sum  = 11'(mag) * 11'd10 + 11'(c[3:0]);
    mag_next = (dec_sum > 11'd127) ? 7'd127 : dec_sum[6:0];
    if (cmd == sclp_pkg::KW_CLOCK) begin
      dec_lim = (dec_idx == 2'd0) ? 7'd23 : 7'd59;
    end else if (cmd == sclp_pkg::KW_ALERT) begin
      dec_lim = 7'd1;
    end else begin
      dec_lim = 7'(sclp_pkg::ROW_COUNT - 1);
    end
    dec_ok   = (!neg || (mag == 7'd0)) && (mag <= dec_lim);
    txt_last = at_end || ((p + 1'b1) == eff_len) || (n == 6'(sclp_pkg::MAX_RESULTS - 1));
    // A finished word continues the parse only if it equals a whole keyword.
    if (state == ST_CMD_WORD) begin
      word_hit = (match[0] && (cnt == sclp_pkg::kw_len(sclp_pkg::KW_CLOCK)))
              || (match[1] && (cnt == sclp_pkg::kw_len(sclp_pkg::KW_PING)))
              || (match[2] && (cnt == sclp_pkg::kw_len(sclp_pkg::KW_CSTYLE)))
              || (match[3] && (cnt == sclp_pkg::kw_len(sclp_pkg::KW_ALERT)))
              || (match[4] && (cnt == sclp_pkg::kw_len(sclp_pkg::KW_ROW)));
    end else begin
      word_hit = (match[5] && (cnt == sclp_pkg::kw_len(sclp_pkg::KW_ARCS)))
              || (match[6] && (cnt == sclp_pkg::kw_len(sclp_pkg::KW_DOTS)))
              || (match[7] && (cnt == sclp_pkg::kw_len(sclp_pkg::KW_DOTTED)));
    end
    unique case (cmd)
      sclp_pkg::KW_CLOCK:  emit_kind = sclp_pkg::KIND_CLOCK;
      sclp_pkg::KW_PING:   emit_kind = sclp_pkg::KIND_PING;
      sclp_pkg::KW_CSTYLE: emit_kind = sclp_pkg::KIND_STYLE;
      default:             emit_kind = sclp_pkg::KIND_ALERT;
    endcase
    unique case (state)
      ST_CMD_WS, ST_STY_WS, ST_COL_WS: take = ws;
      ST_CMD_WORD, ST_STY_WORD:        take = !ws && !at_end;
      ST_DEC_WS:                       take = ws || sign || dig;
      ST_DEC_SIGN, ST_DEC_DIG:         take = dig;
      ST_COL_WORD:                     take = in_word;
      ST_TXT_WS:                       take = (c == sclp_pkg::CH_SPACE);
      ST_TXT:                          take = !at_end && out_free;
      default:                         take = 1'b0;
    endcase
    rd_addr    = (state == ST_COLLECT) ? '0 : (take ? p + 1'b1 : p);
    q_ready    = (state == ST_COLLECT);
    collect_wr = (state == ST_COLLECT) && q_valid && !q_beat.eol
              && (len != AW'(sclp_pkg::LINE_CAPACITY - 1));
  end

  always_ff @(posedge clk) begin
    if (collect_wr) begin
      mem[len] <= q_beat.data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_COLLECT;
      len       <= '0;
      zero_seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready && !emit) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        p <= p + 1'b1;
      end
      unique case (state)
        ST_COLLECT: begin
          if (q_valid) begin
            if (q_beat.eol) begin
              if (len != '0) begin
                eff_len <= zero_seen ? zero_pos : len;
                p       <= '0;
                hours   <= '0;
                minutes <= '0;
                seconds <= '0;
                style   <= '0;
                alert   <= 1'b0;
                row     <= '0;
                state   <= ST_CMD_WS;
              end
            end else if (collect_wr) begin
              len <= len + 1'b1;
              if ((q_beat.data == 8'd0) && !zero_seen) begin
                zero_seen <= 1'b1;
                zero_pos  <= len;
              end
            end else begin
              len       <= '0;
              zero_seen <= 1'b0;
            end
          end
        end
        ST_CMD_WS, ST_STY_WS: begin
          if (!ws) begin
            match <= '1;
            cnt   <= '0;
            state <= (state == ST_CMD_WS) ? ST_CMD_WORD : ST_STY_WORD;
          end
        end
        ST_CMD_WORD, ST_STY_WORD: begin
          if (take) begin
            for (int k = 0; k < 8; k++) begin
              match[k] <= match[k] && (c == sclp_pkg::kw_char(sclp_pkg::kw_t'(3'(k)), cnt));
            end
            if (cnt != 4'd15) begin
              cnt <= cnt + 4'd1;
            end
          end else begin
            neg     <= 1'b0;
            mag     <= '0;
            dec_idx <= '0;
            if (!word_hit) begin
              // Unknown word: the line is dropped.
              state     <= ST_COLLECT;
              len       <= '0;
              zero_seen <= 1'b0;
            end else if (state == ST_CMD_WORD) begin
              if (match[0] && (cnt == sclp_pkg::kw_len(sclp_pkg::KW_CLOCK))) begin
                cmd <= sclp_pkg::KW_CLOCK;  state <= ST_DEC_WS;
              end else if (match[1] && (cnt == sclp_pkg::kw_len(sclp_pkg::KW_PING))) begin
                cmd <= sclp_pkg::KW_PING;   state <= ST_EMIT;
              end else if (match[2] && (cnt == sclp_pkg::kw_len(sclp_pkg::KW_CSTYLE))) begin
                cmd <= sclp_pkg::KW_CSTYLE; state <= ST_STY_WS;
              end else if (match[3] && (cnt == sclp_pkg::kw_len(sclp_pkg::KW_ALERT))) begin
                cmd <= sclp_pkg::KW_ALERT;  state <= ST_DEC_WS;
              end else begin
                cmd <= sclp_pkg::KW_ROW;    state <= ST_DEC_WS;
              end
            end else begin
              if (match[5] && (cnt == sclp_pkg::kw_len(sclp_pkg::KW_ARCS))) begin
                style <= sclp_pkg::STYLE_ARCS;   state <= ST_EMIT;
              end else if (match[6] && (cnt == sclp_pkg::kw_len(sclp_pkg::KW_DOTS))) begin
                style <= sclp_pkg::STYLE_DOTS;   state <= ST_EMIT;
              end else begin
                style <= sclp_pkg::STYLE_DOTTED; state <= ST_EMIT;
              end
            end
          end
        end
        ST_DEC_WS: begin
          if (sign) begin
            neg   <= (c == sclp_pkg::CH_MINUS);
            state <= ST_DEC_SIGN;
          end else if (dig) begin
            mag   <= mag_next;
            state <= ST_DEC_DIG;
          end else if (!ws) begin
            state     <= ST_COLLECT;
            len       <= '0;
            zero_seen <= 1'b0;
          end
        end
        ST_DEC_SIGN: begin
          if (dig) begin
            mag   <= mag_next;
            state <= ST_DEC_DIG;
          end else begin
            state     <= ST_COLLECT;
            len       <= '0;
            zero_seen <= 1'b0;
          end
        end
        ST_DEC_DIG: begin
          if (dig) begin
            mag <= mag_next;
          end else if (!dec_ok) begin
            state     <= ST_COLLECT;
            len       <= '0;
            zero_seen <= 1'b0;
          end else begin
            neg <= 1'b0;
            mag <= '0;
            if (cmd == sclp_pkg::KW_CLOCK) begin
              dec_idx <= dec_idx + 2'd1;
              if (dec_idx == 2'd0) begin
                hours <= mag[4:0];
                state <= ST_DEC_WS;
              end else if (dec_idx == 2'd1) begin
                minutes <= mag[5:0];
                state   <= ST_DEC_WS;
              end else begin
                seconds <= mag[5:0];
                state   <= ST_EMIT;
              end
            end else if (cmd == sclp_pkg::KW_ALERT) begin
              alert <= mag[0];
              state <= ST_EMIT;
            end else begin
              row   <= mag[2:0];
              state <= ST_COL_WS;
            end
          end
        end
        ST_COL_WS: begin
          if (!ws) begin
            ccnt      <= '0;
            neg       <= 1'b0;
            any       <= 1'b0;
            zero_only <= 1'b0;
            xwait     <= 1'b0;
            dig_on    <= 1'b1;
            color     <= '0;
            state     <= ST_COL_WORD;
          end
        end
        ST_COL_WORD: begin
          if (take) begin
            ccnt <= ccnt + 3'd1;
            if ((ccnt == 3'd0) && sign) begin
              neg <= (c == sclp_pkg::CH_MINUS);
            end else if (dig_on) begin
              if (xwait) begin
                xwait <= 1'b0;
                if (hexd) begin
                  color <= {color[27:0], hv};
                end else begin
                  dig_on <= 1'b0;
                end
              end else if (hexd) begin
                color     <= {color[27:0], hv};
                any       <= 1'b1;
                zero_only <= !any && (c == sclp_pkg::CH_ZERO);
              end else if (((c == sclp_pkg::CH_X_LC) || (c == sclp_pkg::CH_X_UC))
                           && zero_only) begin
                xwait     <= 1'b1;
                zero_only <= 1'b0;
              end else begin
                dig_on <= 1'b0;
              end
            end
          end else if (any) begin
            color <= neg ? 32'(32'd0 - color) : color;
            n     <= '0;
            state <= ST_TXT_WS;
          end else begin
            state     <= ST_COLLECT;
            len       <= '0;
            zero_seen <= 1'b0;
          end
        end
        ST_TXT_WS: begin
          if (!take) begin
            state <= ST_TXT;
          end
        end
        ST_TXT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_res   <= '{command_kind: sclp_pkg::KIND_ROW, row_number: row,
                           row_color: color, text_char: c, text_present: !at_end,
                           last_of_line: txt_last, default: '0};
            n         <= n + 6'd1;
            if (txt_last) begin
              state     <= ST_COLLECT;
              len       <= '0;
              zero_seen <= 1'b0;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_res   <= '{command_kind: emit_kind, hours: hours, minutes: minutes,
                           seconds: seconds, style_code: style, alert_on: alert,
                           last_of_line: 1'b1, default: '0};
            state     <= ST_COLLECT;
            len       <= '0;
            zero_seen <= 1'b0;
          end
        end
        default: begin
          state <= ST_COLLECT;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_zero_inside_line: assert property (@(posedge clk) disable iff (rst)
    zero_seen |-> (zero_pos < len))
    else $error("first zero byte lies outside the stored line");

  a_pointer_in_line: assert property (@(posedge clk) disable iff (rst)
    (state != ST_COLLECT) |-> (p <= eff_len))
    else $error("parse pointer ran past the end of the line");

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TXT && out_free && txt_last) |=> (state == ST_COLLECT && len == '0))
    else $error("line not released after its final text beat");
`endif

endmodule

// ===== rtl/core/serial_command_line_parser_unit.sv =====
// Top level of the serial command line parser.
//
// Received characters enter on the s_ side one beat each and are collected into a
// line store of up to 63 characters; a character that would overflow the store
// discards the line. CR or LF ends a non-empty line, which is then parsed: CLOCK h m s,
// PING, CSTYLE arcs|dots|dotted-arcs, ALERT 0|1 and ROW index color text. A valid
// line gives one result beat on the m_ side, or for ROW one beat per text character
// (leading spaces skipped, at most 56, an empty text gives one beat with
// text_present low); the final beat of a line carries tlast. Invalid lines give
// nothing. A plain character is stored as soon as it reaches the back part, so the
// block keeps up with one character per cycle between lines. At a line end the
// back part walks the stored line character by character, and gives one ROW text
// beat per cycle while the output is free; during that walk the front part and its
// four-beat queue keep accepting characters until the queue fills.
module serial_command_line_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [4:0] hours, [10:5] minutes, [16:11] seconds,
                                 // [18:17] style_code, [19] alert_on, [22:20] row_number,
                                 // [54:23] row_color, [62:55] text_char, [63] zero
  output logic [3:0]  m_tuser,   // [2:0] command_kind, [3] text_present
  output logic        m_tlast
);

  logic               f_valid;
  logic               f_ready;
  sclp_pkg::beat_t    f_beat;
  logic               q_valid;
  logic               q_ready;
  sclp_pkg::beat_t    q_beat;
  sclp_pkg::result_t  res;

  sclp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .f_valid  (f_valid),
    .f_ready  (f_ready),
    .f_beat   (f_beat)
  );

  sclp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_beat   (f_beat),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_beat  (q_beat)
  );

  sclp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_beat    (q_beat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  // Pack the result fields, first field in the lowest bits.
  assign m_tdata = {1'b0, res.text_char, res.row_color, res.row_number, res.alert_on,
                    res.style_code, res.seconds, res.minutes, res.hours};
  assign m_tuser = {res.text_present, res.command_kind};
  assign m_tlast = res.last_of_line;

endmodule

// ===== verif/sclp_checker.sv =====
// Checker of the serial command line parser: predicts result beats from received bytes.
module sclp_checker
  import sclp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic [3:0]  m_tuser,
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending
);

  logic [7:0]  rx_line [LINE_CAPACITY];
  int unsigned rx_count;
  int unsigned eff_len;
  result_t     expected_beats [$];

  assign pending = expected_beats.size();

  function automatic logic [7:0] chr(int unsigned p);
    return (p < eff_len && p < LINE_CAPACITY) ? rx_line[p] : 8'd0;
  endfunction

  function automatic bit is_ws(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
           c == CH_FF || c == CH_CR;
  endfunction

  function automatic bit is_dig(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_ZERO + 8'd9;
  endfunction

  function automatic int unsigned hexv(logic [7:0] c);
    if (is_dig(c)) return c - CH_ZERO;
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return 16;
  endfunction

  function automatic int unsigned skip_ws(int unsigned p);
    while (p < eff_len && is_ws(chr(p))) p++;
    return p;
  endfunction

  function automatic bit read_dec(inout int unsigned p, output int v);
    int unsigned q;
    int unsigned mag;
    bit          neg;
    q   = skip_ws(p);
    mag = 0;
    neg = 0;
    v   = 0;
    if (chr(q) == CH_PLUS || chr(q) == CH_MINUS) begin
      neg = chr(q) == CH_MINUS;
      q++;
    end
    if (!is_dig(chr(q))) return 0;
    while (is_dig(chr(q))) begin
      mag = mag * 10 + (chr(q) - CH_ZERO);
      if (mag > 1000000) mag = 1000000;
      q++;
    end
    v = neg ? -int'(mag) : int'(mag);
    p = q;
    return 1;
  endfunction

  function automatic int unsigned read_word(int unsigned p, int unsigned maxlen,
                                            output int unsigned s, output int unsigned len);
    int unsigned q;
    q = skip_ws(p);
    s = q;
    while (q < eff_len && !is_ws(chr(q)) && q - s < maxlen) q++;
    len = q - s;
    return q;
  endfunction

  function automatic bit word_is(int unsigned s, int unsigned len, string w);
    for (int unsigned i = 0; i < len; i++)
      if (i >= w.len() || w[i] != chr(s + i)) return 0;
    return w.len() == len;
  endfunction

  function automatic bit read_color(int unsigned s, int unsigned len, output logic [31:0] col);
    int unsigned e;
    int unsigned q;
    bit          neg;
    bit          any;
    logic [31:0] v;
    e   = s + len;
    q   = s;
    neg = 0;
    any = 0;
    v   = '0;
    if (q < e && (chr(q) == CH_PLUS || chr(q) == CH_MINUS)) begin
      neg = chr(q) == CH_MINUS;
      q++;
    end
    if (q + 2 < e && chr(q) == CH_ZERO && (chr(q + 1) == CH_X_LC || chr(q + 1) == CH_X_UC)
        && hexv(chr(q + 2)) < 16)
      q += 2;
    while (q < e && hexv(chr(q)) < 16) begin
      v   = {v[27:0], 4'(hexv(chr(q)))};
      any = 1;
      q++;
    end
    col = neg ? 32'd0 - v : v;
    return any;
  endfunction

  // Parses the finished line and queues the beats it should produce.
  task automatic predict_line();
    int unsigned s, len, p, n;
    int          a, b, c;
    logic [31:0] col;
    result_t     r;
    r = '0;
    p = read_word(0, 7, s, len);
    if (len == 0) return;
    if (word_is(s, len, "CLOCK")) begin
      if (!read_dec(p, a) || !read_dec(p, b) || !read_dec(p, c)) return;
      if (a < 0 || a > 23 || b < 0 || b > 59 || c < 0 || c > 59) return;
      r.command_kind = KIND_CLOCK;
      r.hours = a[4:0]; r.minutes = b[5:0]; r.seconds = c[5:0];
      r.last_of_line = 1'b1;
      expected_beats.push_back(r);
    end else if (word_is(s, len, "PING")) begin
      r.command_kind = KIND_PING;
      r.last_of_line = 1'b1;
      expected_beats.push_back(r);
    end else if (word_is(s, len, "CSTYLE")) begin
      void'(read_word(p, 15, s, len));
      if (len == 0) return;
      if (word_is(s, len, "arcs")) r.style_code = STYLE_ARCS;
      else if (word_is(s, len, "dots")) r.style_code = STYLE_DOTS;
      else if (word_is(s, len, "dotted-arcs")) r.style_code = STYLE_DOTTED;
      else return;
      r.command_kind = KIND_STYLE;
      r.last_of_line = 1'b1;
      expected_beats.push_back(r);
    end else if (word_is(s, len, "ALERT")) begin
      if (!read_dec(p, a) || (a != 0 && a != 1)) return;
      r.command_kind = KIND_ALERT;
      r.alert_on = a[0];
      r.last_of_line = 1'b1;
      expected_beats.push_back(r);
    end else if (word_is(s, len, "ROW")) begin
      if (!read_dec(p, a) || a < 0 || a >= ROW_COUNT) return;
      p = read_word(p, 7, s, len);
      if (len == 0 || !read_color(s, len, col)) return;
      while (p < eff_len && chr(p) == CH_SPACE) p++;
      n = 0;
      do begin
        r = '0;
        r.command_kind = KIND_ROW;
        r.row_number = a[2:0];
        r.row_color = col;
        if (p < eff_len) begin
          r.text_char = chr(p);
          r.text_present = 1'b1;
          p++;
        end
        expected_beats.push_back(r);
        n++;
      end while (p < eff_len && n < MAX_RESULTS);
      expected_beats[expected_beats.size() - 1].last_of_line = 1'b1;
    end
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      rx_count   = 0;
      fail_count = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (s_tdata == CH_LF || s_tdata == CH_CR) begin
          if (rx_count > 0) begin
            eff_len = rx_count;
            for (int unsigned i = 0; i < rx_count; i++)
              if (rx_line[i] == 8'd0) begin
                eff_len = i;
                break;
              end
            predict_line();
            rx_count = 0;
          end
        end else if (rx_count < LINE_CAPACITY - 1) begin
          rx_line[rx_count] = s_tdata;
          rx_count = rx_count + 1;
        end else begin
          rx_count = 0;
        end
      end
      if (m_tvalid && m_tready) begin
        if (expected_beats.size() == 0) begin
          $display("%0t mismatch: expected no beat, actual tdata %0h tuser %0h tlast %0b",
                   $time, m_tdata, m_tuser, m_tlast);
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          check_field("command_kind", want.command_kind, m_tuser[2:0]);
          check_field("hours", want.hours, m_tdata[4:0]);
          check_field("minutes", want.minutes, m_tdata[10:5]);
          check_field("seconds", want.seconds, m_tdata[16:11]);
          check_field("style_code", want.style_code, m_tdata[18:17]);
          check_field("alert_on", want.alert_on, m_tdata[19]);
          check_field("row_number", want.row_number, m_tdata[22:20]);
          check_field("row_color", want.row_color, m_tdata[54:23]);
          check_field("text_char", want.text_char, m_tdata[62:55]);
          check_field("pad", 0, m_tdata[63]);
          check_field("text_present", want.text_present, m_tuser[3]);
          check_field("last_of_line", want.last_of_line, m_tlast);
        end
      end
    end
  end

endmodule

// ===== verif/tb_serial_command_line_parser_unit.sv =====
// Testbench top of the serial command line parser: stimulus, flow control and verdict.
module tb_serial_command_line_parser_unit;
  import sclp_pkg::*;

  localparam int DRAIN_MARK  = -1;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;
  int          fail_count;
  int          pending;
  int          cycle_count;
  bit          hold_request;
  int          tx_bytes [$];

  serial_command_line_parser_unit dut (.*);

  sclp_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1;
    repeat (12) @(posedge clk);
    rst <= 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end
  initial cycle_count = 0;

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) tx_bytes.push_back(s[i]);
  endfunction

  // A line ends with LF or CR at random.
  function automatic void push_line(string s);
    push_text(s);
    tx_bytes.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
  endfunction

  function automatic string rand_text(int n);
    string t;
    t = "";
    for (int i = 0; i < n; i++) t = {t, string'(8'($urandom_range(33, 126)))};
    return t;
  endfunction

  initial begin
    // A zero byte cuts the line short, so the seconds read as 5.
    push_text("CLOCK 23 59 5");
    tx_bytes.push_back(0);
    push_line("9");
    push_line("CSTYLE dots");
    push_line("ALERT 1");
    push_line("ROW 7 -0x1  hi");
    // Longest row text that fits the store: exactly the most beats a line can give.
    push_line({"ROW 0 0\t", rand_text(55)});
    tx_bytes.push_back(DRAIN_MARK);
    // The 64th character overflows the store; PING then starts a fresh line.
    push_line({rand_text(64), "PING"});
    push_line("");
  end

  // Sender: bursts of beats separated by idle gaps.
  initial begin
    int item;
    int burst_left;
    int gap;
    s_tvalid = 0;
    s_tdata = '0;
    hold_request = 0;
    burst_left = 0;
    @(negedge rst);
    @(posedge clk);
    // Let the receiver hold off while the first lines stream in.
    hold_request = 1;
    while (tx_bytes.size() > 0) begin
      item = tx_bytes.pop_front();
      if (item == DRAIN_MARK) begin
        s_tvalid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        continue;
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          s_tvalid <= 0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      s_tvalid <= 1;
      s_tdata <= item[7:0];
      @(posedge clk);
      while (!s_tready) @(posedge clk);
    end
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Receiver: one long hold-off on request, otherwise alternating windows of
  // steady readiness and random stalls.
  initial begin
    int hold_left;
    int phase;
    m_tready = 0;
    hold_left = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_request) begin
        hold_request = 0;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 0;
      end else if ((phase / 80) % 2 == 0) begin
        m_tready <= 1;
      end else begin
        m_tready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

endmodule
